>>> design/mbet_pkg.sv
// Shared types and constants of the Mandelbrot escape-time pixel engine.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mbet_pkg;

   // image geometry
   localparam int MAX_DIM   = 4096;
   localparam int INDEX_W   = 12;

   // number formats
   localparam int COORD_W   = 32;                 // Q4.28
   localparam int STEP_W    = 31;
   localparam int ITER_W    = 16;
   localparam int SHADE_W   = 8;
   localparam int FRAC_W    = 28;
   localparam int PROD_W    = 2 * COORD_W;       // Q8.56
   localparam int OFFS_W    = STEP_W + INDEX_W;  // pixel_step * index

   // 4.0 in Q8.56
   localparam logic [PROD_W-1:0] ESCAPE_BOUND = PROD_W'(64'h0400_0000_0000_0000);

   // shade division: dividend is count * 255
   localparam int DIVIDEND_W = ITER_W + SHADE_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_RE       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN_IM       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_STEP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_LIMIT = 3'd3;

   localparam logic [COORD_W-1:0] ORIGIN_RE_RESET = 32'hDE00_0000;   // -570425344
   localparam logic [COORD_W-1:0] ORIGIN_IM_RESET = 32'hE800_0000;   // -402653184
   localparam logic [STEP_W-1:0]  PIXEL_STEP_RESET = 31'd1006632;
   localparam logic [ITER_W-1:0]  ITER_LIMIT_RESET = 16'd1024;

   typedef struct packed {
      logic [INDEX_W-1:0] pixel_row;
      logic [INDEX_W-1:0] pixel_col;
   } req_type;

   typedef struct packed {
      logic [SHADE_W-1:0] shade;
      logic [ITER_W-1:0]  iteration_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load_pixel;   // capture indices, form pixel offsets
      logic load_c;       // saturate c, seed z, clear count
      logic mul;          // register squares and cross product
      logic update;       // advance z and count
      logic div_start;    // start shade division
      logic out_load;     // load result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic k_done;       // count has reached the limit
      logic escaped;      // |z|^2 > 4
      logic limit_zero;
      logic div_busy;
   } status_type;

endpackage

>>> design/mbet_div.sv
// Restoring divider for the shade: one quotient bit per cycle.
// Depends on mbet_pkg.
`timescale 1ns / 1ps

module mbet_div
   import mbet_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [ITER_W-1:0]     divisor,
   output logic                  busy,
   output logic [SHADE_W-1:0]    quotient
);

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ITER_W-1:0]     rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [ITER_W:0]       trial;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? ITER_W'(trial - {1'b0, divisor}) : trial[ITER_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // the quotient never exceeds 255 since count <= limit
   assign busy     = busy_ff;
   assign quotient = quo_ff[SHADE_W-1:0];

endmodule

>>> design/mbet_datapath.sv
// Datapath: configuration registers, pixel mapping, z iteration and result register.
// Depends on mbet_pkg and mbet_div.
`timescale 1ns / 1ps

module mbet_datapath
   import mbet_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  req_type                req_data,
   output rsp_type                rsp_data,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [PROD_W-1:0] SAT_MIN = -PROD_W'(64'sh0000_0000_8000_0000);

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > SAT_MAX) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else if (v < SAT_MIN) begin
         r = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

   // configuration
   logic signed [COORD_W-1:0] origin_re_ff, origin_im_ff;
   logic [STEP_W-1:0]         step_ff;
   logic [ITER_W-1:0]         limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff <= ORIGIN_RE_RESET;
         origin_im_ff <= ORIGIN_IM_RESET;
         step_ff      <= PIXEL_STEP_RESET;
         limit_ff     <= ITER_LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ORIGIN_RE:       origin_re_ff <= csr_wdata[COORD_W-1:0];
            CSR_ORIGIN_IM:       origin_im_ff <= csr_wdata[COORD_W-1:0];
            CSR_PIXEL_STEP:      step_ff      <= csr_wdata[STEP_W-1:0];
            CSR_ITERATION_LIMIT: limit_ff     <= csr_wdata[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   // pixel mapping: clamp indices, then offsets
   logic [INDEX_W-1:0] row_clamped, col_clamped;
   logic [OFFS_W-1:0]  row_offs_ff, col_offs_ff;

   assign row_clamped = (int'(req_data.pixel_row) >= MAX_DIM) ? INDEX_W'(MAX_DIM - 1)
                                                              : req_data.pixel_row;
   assign col_clamped = (int'(req_data.pixel_col) >= MAX_DIM) ? INDEX_W'(MAX_DIM - 1)
                                                              : req_data.pixel_col;

   always_ff @(posedge clock) begin
      if (cmd.load_pixel) begin
         row_offs_ff <= step_ff * row_clamped;
         col_offs_ff <= step_ff * col_clamped;
      end
   end

   logic signed [OFFS_W:0] cr_sum, ci_sum;
   assign cr_sum = $signed({{(OFFS_W+1-COORD_W){origin_re_ff[COORD_W-1]}}, origin_re_ff})
                 + $signed({1'b0, col_offs_ff});
   assign ci_sum = $signed({{(OFFS_W+1-COORD_W){origin_im_ff[COORD_W-1]}}, origin_im_ff})
                 + $signed({1'b0, row_offs_ff});

   // iteration
   logic signed [COORD_W-1:0] cr_ff, ci_ff, a_ff, b_ff;
   logic [ITER_W-1:0]         k_ff;
   logic signed [PROD_W-1:0]  a2_ff, b2_ff, ab_ff;
   logic signed [PROD_W-1:0]  re_sum, im_sum;
   logic [PROD_W-1:0]         mag;

   // adding c scaled up before the shift leaves the floor unchanged
   assign re_sum = a2_ff - b2_ff + $signed({{4{cr_ff[COORD_W-1]}}, cr_ff, FRAC_W'(0)});
   assign im_sum = ab_ff + $signed({{5{ci_ff[COORD_W-1]}}, ci_ff, (FRAC_W-1)'(0)});
   assign mag    = $unsigned(a2_ff) + $unsigned(b2_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_c) begin
         cr_ff <= sat_coord(PROD_W'(cr_sum));
         ci_ff <= sat_coord(PROD_W'(ci_sum));
         a_ff  <= sat_coord(PROD_W'(cr_sum));
         b_ff  <= sat_coord(PROD_W'(ci_sum));
      end else if (cmd.update) begin
         a_ff <= sat_coord(re_sum >>> FRAC_W);
         b_ff <= sat_coord(im_sum >>> (FRAC_W - 1));
      end
      if (cmd.mul) begin
         a2_ff <= a_ff * a_ff;
         b2_ff <= b_ff * b_ff;
         ab_ff <= a_ff * b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else if (cmd.load_c) begin
         k_ff <= '0;
      end else if (cmd.update) begin
         k_ff <= k_ff + 1'b1;
      end
   end

   // shade = 255 - k*255/limit
   logic [DIVIDEND_W-1:0] dividend;
   logic [SHADE_W-1:0]    quotient;
   logic                  div_busy;

   assign dividend = {k_ff, SHADE_W'(0)} - DIVIDEND_W'(k_ff);

   mbet_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (limit_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.shade           <= (limit_ff == '0) ? {SHADE_W{1'b1}}
                                                    : {SHADE_W{1'b1}} - quotient;
         rsp_ff.iteration_count <= k_ff;
      end
   end

   assign rsp_data          = rsp_ff;
   assign status.k_done     = k_ff >= limit_ff;
   assign status.escaped    = mag > ESCAPE_BOUND;
   assign status.limit_zero = limit_ff == '0;
   assign status.div_busy   = div_busy;

endmodule

>>> design/mbet_ctrl.sv
// Controller: sequences mapping, iteration, shade division and result hand-off.
// Depends on mbet_pkg.
`timescale 1ns / 1ps

module mbet_ctrl
   import mbet_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP,
      ST_COORD,
      ST_MUL,
      ST_UPD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_pixel = 1'b1;
               state_in       = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.load_c = 1'b1;
            state_in   = ST_COORD;
         end
         ST_COORD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (status.k_done) begin
               cmd.div_start = !status.limit_zero;
               state_in      = status.limit_zero ? ST_DONE : ST_DIV;
            end else begin
               cmd.mul  = 1'b1;
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            if (status.escaped) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/mandelbrot_escape_time_pixel.sv
// Top level of the Mandelbrot escape-time pixel engine.
// Depends on mbet_pkg, mbet_ctrl and mbet_datapath.
`timescale 1ns / 1ps

// Usage
//  - req_ channel: one beat carries a pixel row and column. req_ready is high
//    while the engine is free; a beat is taken when req_valid and req_ready
//    are both high.
//  - rsp_ channel: one beat per pixel with the shade and the iteration count,
//    held in an output register until rsp_ready takes it. The next pixel is
//    accepted while that beat still waits; the engine only stops before
//    loading a new result into a register that is still full.
//  - csr_ port: write origin_re (0), origin_im (1), pixel_step (2) and
//    iteration_limit (3) while idle; other indices are dropped.
//  - Sequence: a pixel is mapped (offsets, then c and z); each iteration
//    registers the squares of z, tests them for escape and otherwise updates
//    z and the count; then the bit-serial shade divider runs and the result
//    is handed off; a zero limit skips the divider.
//  - Throughput: one pixel at a time; the next beat can be taken in the cycle
//    after the result is loaded.
//  - Reset (synchronous, active high) restores the default view and limit
//    and empties the result register.

module mandelbrot_escape_time_pixel
   import mbet_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // sequencing: accept, iterate, divide, hand off
   mbet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // arithmetic, configuration and result register
   mbet_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
